>>> sv/prb_pkg.sv
package prb_pkg;

  localparam int DATA_W = 64;
  localparam int VAL_W = 63;
  localparam int CNT_W = 15;
  localparam int ADDR_W = 5;

  localparam logic [VAL_W-1:0] CLOSED_SPAN_DEF = 63'd2147483647;

  localparam logic [DATA_W-1:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] SMIN = 64'h8000_0000_0000_0000;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_INTERVAL = 2'd1;
  localparam logic [1:0] REG_SLICES = 2'd2;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_NEG = 1'b1;

endpackage

>>> sv/prb_if.sv
interface prb_in_if;
  logic valid;
  logic ready;
  logic signed [63:0] coord;
  modport source (output valid, output coord, input ready);
  modport sink (input valid, input coord, output ready);
endinterface

interface prb_out_if;
  logic valid;
  logic ready;
  logic signed [63:0] part_lo;
  logic signed [63:0] part_hi;
  logic status;
  modport source (output valid, output part_lo, output part_hi, output status,
                  input ready);
  modport sink (input valid, input part_lo, input part_hi, input status,
                output ready);
endinterface

>>> sv/partition_range_bucketizer_top.sv
// Channel  Dir  Payload                                   Handshake
// din      in   coord (64 signed)                         valid/ready
// dout     out  part_lo, part_hi (64 signed), status      valid/ready
// cfg      in   APB: closed_mode, bucket_len, slice_count at 0x00/0x08/0x10
//
// One word is taken per cycle while dout is not stalled and no slice width is being
// computed. Each result passes one input register, 63 stages of a one-bit-per-stage
// restoring divider, a middle register that forms the floor multiple, and the output
// register. A write of slice_count starts a serial division of the closed span;
// din.ready is low while it runs. Reset is synchronous and empties the pipeline. A
// stall at dout freezes every stage together, so nothing is lost or repeated.
module partition_range_bucketizer_top #(
  parameter logic [prb_pkg::VAL_W-1:0] CLOSED_SPAN = prb_pkg::CLOSED_SPAN_DEF
) (
  input  logic clk,
  input  logic rst,
  prb_in_if.sink din,
  prb_out_if.source dout,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [prb_pkg::ADDR_W-1:0] paddr,
  input  logic [prb_pkg::DATA_W-1:0] pwdata,
  output logic [prb_pkg::DATA_W-1:0] prdata,
  output logic pready
);
  import prb_pkg::*;

  // Configuration registers.
  logic             closed_mode;
  logic [VAL_W-1:0] bucket_len;
  logic [CNT_W-1:0] slice_count;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[4:3])
      REG_MODE:     prdata = {{(DATA_W-1){1'b0}}, closed_mode};
      REG_INTERVAL: prdata = {1'b0, bucket_len};
      REG_SLICES:   prdata = {{(DATA_W-CNT_W){1'b0}}, slice_count};
      default:      prdata = '0;
    endcase
  end

  // Slice width and start of the last slice, computed by a serial divider of the
  // span by the slice count after each write of slice_count.
  logic             busy;
  logic [5:0]       cnt;
  logic [CNT_W-1:0] nz;
  logic [CNT_W-1:0] wrem;
  logic [VAL_W-1:0] wq;
  logic [VAL_W-1:0] slice_w;
  logic [VAL_W-1:0] last;
  logic [CNT_W:0]   wtrial;
  logic [CNT_W:0]   wdiff;
  logic             wbit;
  logic [VAL_W-1:0] wq_next;
  logic [CNT_W-1:0] wrem_next;

  assign wtrial = {wrem, CLOSED_SPAN[6'(VAL_W-1) - cnt]};
  assign wdiff = wtrial - {1'b0, nz};
  assign wbit = wtrial >= {1'b0, nz};
  assign wq_next = {wq[VAL_W-2:0], wbit};
  assign wrem_next = wbit ? wdiff[CNT_W-1:0] : wtrial[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      closed_mode <= 1'b0;
      bucket_len <= VAL_W'(1);
      slice_count <= CNT_W'(1);
      busy <= 1'b0;
      cnt <= '0;
      slice_w <= CLOSED_SPAN;
      last <= '0;
    end else begin
      if (wr_en) begin
        case (paddr[4:3])
          REG_MODE:     closed_mode <= pwdata[0];
          REG_INTERVAL: bucket_len <= pwdata[VAL_W-1:0];
          REG_SLICES: begin
            slice_count <= pwdata[CNT_W-1:0];
            busy <= 1'b1;
            cnt <= '0;
          end
          default: ;
        endcase
      end
      if (busy && !(wr_en && paddr[4:3] == REG_SLICES)) begin
        if (cnt == 6'(VAL_W-1)) begin
          busy <= 1'b0;
          slice_w <= wq_next;
          // width*(n-1) = (span - span mod n) - width
          last <= CLOSED_SPAN - VAL_W'(wrem_next) - wq_next;
        end
        cnt <= cnt + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && paddr[4:3] == REG_SLICES) begin
      nz <= (pwdata[CNT_W-1:0] == '0) ? CNT_W'(1) : pwdata[CNT_W-1:0];
      wrem <= '0;
      wq <= '0;
    end else if (busy) begin
      wrem <= wrem_next;
      wq <= wq_next;
    end
  end

  // Divider pipeline. Negative words divide ~coord, the magnitude of
  // coord + 1; non-negative words divide the low 63 bits.
  logic             adv;
  logic             p_valid;
  logic             p_neg;
  logic [VAL_W-1:0] p_mag;
  logic [VAL_W-1:0] p_rem;
  logic [VAL_W-1:0] divisor;
  logic             wzero;
  logic [VAL_W-1:0] in_mag;

  assign wzero = (slice_w == '0);
  assign divisor = closed_mode ? (wzero ? VAL_W'(1) : slice_w)
                               : ((bucket_len == '0) ? VAL_W'(1) : bucket_len);
  assign adv = !dout.valid || dout.ready;
  assign din.ready = adv && !busy;
  assign in_mag = din.coord[DATA_W-1] ? ~din.coord[VAL_W-1:0] : din.coord[VAL_W-1:0];

  prb_divpipe u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (din.valid && !busy),
    .in_neg    (din.coord[DATA_W-1]),
    .in_mag    (in_mag),
    .divisor   (divisor),
    .out_valid (p_valid),
    .out_neg   (p_neg),
    .out_mag   (p_mag),
    .out_rem   (p_rem)
  );

  // Middle stage. The floor multiple is the dividend minus the remainder; the
  // last-slice test runs beside it so that the output stage only adds, negates
  // and selects.
  logic             m_valid;
  logic             m_neg;
  logic [VAL_W-1:0] m_flr;
  logic             m_top;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_neg <= p_neg;
      m_flr <= p_mag - p_rem;
      m_top <= (p_mag >= last) || wzero;
    end
  end

  // Result stage.
  logic [DATA_W-1:0] sum_len;
  logic [DATA_W-1:0] sum_w;
  logic [DATA_W-1:0] start_next;
  logic [DATA_W-1:0] end_next;
  logic              status_next;
  logic [VAL_W-1:0]  cs;

  assign sum_len = {1'b0, m_flr} + {1'b0, bucket_len};
  assign sum_w = {1'b0, m_flr} + {1'b0, slice_w};

  always_comb begin
    status_next = STATUS_OK;
    cs = m_flr;
    if (closed_mode) begin
      if (m_neg) begin
        status_next = STATUS_NEG;
        start_next = '0;
        end_next = '0;
      end else begin
        if (m_top) begin
          cs = last;
          end_next = SMAX;
        end else begin
          end_next = sum_w;
        end
        start_next = (cs == '0) ? SMIN : {1'b0, cs};
      end
    end else if (!m_neg) begin
      // A zero interval acts as one: the floor is the value and the end is value + 1.
      start_next = {1'b0, m_flr};
      if (bucket_len == '0) begin
        end_next = (m_flr == SMAX[VAL_W-1:0]) ? SMAX : {1'b0, m_flr} + 64'd1;
      end else begin
        end_next = sum_len[DATA_W-1] ? SMAX : sum_len;
      end
    end else begin
      end_next = -{1'b0, m_flr};
      if (bucket_len == '0) begin
        start_next = (m_flr == SMAX[VAL_W-1:0]) ? SMIN : -({1'b0, m_flr} + 64'd1);
      end else begin
        start_next = (sum_len > SMIN) ? SMIN : -sum_len;
      end
    end
  end

  logic o_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout.part_lo <= start_next;
      dout.part_hi <= end_next;
      dout.status <= status_next;
    end
  end

  assign dout.valid = o_valid;

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready |-> !busy)
    else $error("word taken during slice width computation");

  a_status_closed: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.status |-> closed_mode)
    else $error("error status in open mode");

  a_closed_start: assert property (@(posedge clk) disable iff (rst)
    dout.valid && closed_mode && !dout.status |-> dout.part_lo != '0)
    else $error("closed slice start of zero not mapped to minimum");

endmodule

>>> sv/prb_divpipe.sv
module prb_divpipe (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic in_neg,
  input  logic [prb_pkg::VAL_W-1:0] in_mag,
  input  logic [prb_pkg::VAL_W-1:0] divisor,
  output logic out_valid,
  output logic out_neg,
  output logic [prb_pkg::VAL_W-1:0] out_mag,
  output logic [prb_pkg::VAL_W-1:0] out_rem
);
  import prb_pkg::*;

  // Stage 0 holds the word as taken; stage k+1 has consumed dividend bit VAL_W-1-k.
  logic             vld [0:VAL_W];
  logic             neg [0:VAL_W];
  logic [VAL_W-1:0] mag [0:VAL_W];
  logic [VAL_W-1:0] rem [0:VAL_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg[0] <= in_neg;
      mag[0] <= in_mag;
      rem[0] <= '0;
    end
  end

  for (genvar k = 0; k < VAL_W; k++) begin : g_stage
    logic [VAL_W:0] trial;
    logic [VAL_W:0] diff;
    assign trial = {rem[k], mag[k][VAL_W-1-k]};
    assign diff = trial - {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg[k+1] <= neg[k];
        mag[k+1] <= mag[k];
        rem[k+1] <= (trial >= {1'b0, divisor}) ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
      end
    end
  end

  assign out_valid = vld[VAL_W];
  assign out_neg = neg[VAL_W];
  assign out_mag = mag[VAL_W];
  assign out_rem = rem[VAL_W];

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    out_valid && divisor != '0 |-> out_rem < divisor)
    else $error("remainder not below divisor");

  a_valid_moves: assert property (@(posedge clk) disable iff (rst)
    en && vld[0] |=> vld[1])
    else $error("word lost in first stage");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(out_valid))
    else $error("last stage changed while stalled");

endmodule
